// ===== rtl/core/ecfat_pkg.sv =====
// ecfat_pkg: shared types, constants and tables for the epoch to fat timestamp pipeline
// no dependencies; used by every module under rtl/core except ecfat_checker
`default_nettype none

package ecfat_pkg;

   // pipeline depths
   localparam int unsigned CivilStages = 8;
   localparam int unsigned TodStages   = 4;
   localparam int unsigned TodDelay    = CivilStages - TodStages;

   // seconds to days, v = t + 2^31 + 74752 so that floor(t / 86400) = v / 86400 - 24856
   localparam logic [32:0] BiasOffset = 33'd74752;
   localparam logic [16:0] RecipDay   = 17'd99420;     // floor(2^26 / 675)
   localparam logic [9:0]  DayUnit    = 10'd675;       // 86400 / 128
   localparam logic [19:0] DaysBase   = 20'd694612;    // 719468 - 24856

   // era and day of era
   localparam logic [19:0] EraFiveStart = 20'd730485;
   localparam logic [19:0] EraFourStart = 20'd584388;
   localparam logic [17:0] EraLastDay   = 18'd146096;
   localparam logic [17:0] CenturyDays  = 18'd36524;
   localparam logic [10:0] QuadLess     = 11'd1460;
   localparam logic [7:0]  RecipQuad    = 8'd179;      // floor(2^18 / 1460)
   localparam logic [9:0]  RecipYear    = 10'd718;     // floor(2^18 / 365)
   localparam logic [8:0]  YearDays     = 9'd365;
   localparam logic [8:0]  CenturyYears = 9'd100;
   localparam logic [11:0] EraFourYear  = 12'd1600;
   localparam logic [11:0] EraFiveYear  = 12'd2000;
   localparam logic [11:0] BaseYear     = 12'd1980;
   localparam logic [3:0]  MonthsInYear = 4'd12;

   // time of day
   localparam logic [5:0]  RecipHour = 6'd36;          // floor(2^17 / 3600)
   localparam logic [11:0] HourSecs  = 12'd3600;
   localparam logic [6:0]  RecipMin  = 7'd68;          // floor(2^12 / 60)
   localparam logic [5:0]  MinSecs   = 6'd60;

   // register reset values
   localparam logic [11:0] ResetYear  = 12'd2020;
   localparam logic [3:0]  ResetMonth = 4'd1;
   localparam logic [4:0]  ResetDay   = 5'd1;

   typedef enum logic [1:0] {
      CSR_YEAR  = 2'd0,
      CSR_MONTH = 2'd1,
      CSR_DAY   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic        valid;
      logic        zero;
      logic [19:0] days;
      logic [16:0] tod_secs;
   } split_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] mins;
      logic [5:0] secs;
   } tod_type;

   typedef struct packed {
      logic        valid;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } civil_type;

   // first day of each month counted from march 1
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] start_day;
      unique case (mp)
         4'd0:  start_day = 9'd0;
         4'd1:  start_day = 9'd31;
         4'd2:  start_day = 9'd61;
         4'd3:  start_day = 9'd92;
         4'd4:  start_day = 9'd122;
         4'd5:  start_day = 9'd153;
         4'd6:  start_day = 9'd184;
         4'd7:  start_day = 9'd214;
         4'd8:  start_day = 9'd245;
         4'd9:  start_day = 9'd275;
         4'd10: start_day = 9'd306;
         4'd11: start_day = 9'd337;
         default: start_day = 9'd0;
      endcase
      return start_day;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ecfat_split.sv =====
// ecfat_split: three register stages that split signed epoch seconds into days and seconds of day
// depends on ecfat_pkg
`default_nettype none

module ecfat_split (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start_accept,
   input  logic signed [31:0]    epoch_seconds,
   output ecfat_pkg::split_type  split_out
);

   logic        s1_valid_ff;
   logic        s1_zero_ff;
   logic [31:0] s1_secs_ff;

   logic        s2_valid_ff;
   logic        s2_zero_ff;
   logic [16:0] s2_quot_ff;
   logic [25:0] s2_blocks_ff;
   logic [6:0]  s2_low_ff;

   ecfat_pkg::split_type s3_ff;
   ecfat_pkg::split_type s3_in;

   logic [32:0] biased;
   logic [42:0] recip_prod;
   logic [16:0] s2_quot_in;
   logic [26:0] quot_mul;
   logic [26:0] rem_raw;
   logic        rem_fix;
   logic [26:0] rem_adj;
   logic [16:0] quot_adj;

   // stage 2: biased count, reciprocal estimate of the 675 quotient
   assign biased     = {1'b0, ~s1_secs_ff[31], s1_secs_ff[30:0]} + ecfat_pkg::BiasOffset;
   assign recip_prod = 43'(biased[32:7]) * 43'(ecfat_pkg::RecipDay);
   assign s2_quot_in = recip_prod[42:26];

   // stage 3: one correction step
   assign quot_mul = 27'(s2_quot_ff) * 27'(ecfat_pkg::DayUnit);
   assign rem_raw  = 27'(s2_blocks_ff) - quot_mul;
   assign rem_fix  = (rem_raw >= 27'(ecfat_pkg::DayUnit));
   assign rem_adj  = rem_fix ? (rem_raw - 27'(ecfat_pkg::DayUnit)) : rem_raw;
   assign quot_adj = s2_quot_ff + 17'(rem_fix);

   always_comb begin
      s3_in.valid    = s2_valid_ff;
      s3_in.zero     = s2_zero_ff;
      s3_in.days     = 20'(quot_adj) + ecfat_pkg::DaysBase;
      s3_in.tod_secs = {rem_adj[9:0], s2_low_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= start_accept;
         s2_valid_ff <= s1_valid_ff;
         s3_ff.valid <= s3_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_secs_ff     <= epoch_seconds;
      s1_zero_ff     <= (epoch_seconds == 32'sd0);
      s2_zero_ff     <= s1_zero_ff;
      s2_quot_ff     <= s2_quot_in;
      s2_blocks_ff   <= biased[32:7];
      s2_low_ff      <= biased[6:0];
      s3_ff.zero     <= s3_in.zero;
      s3_ff.days     <= s3_in.days;
      s3_ff.tod_secs <= s3_in.tod_secs;
   end

   assign split_out = s3_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ecfat_tod.sv =====
// ecfat_tod: four register stages that split seconds of day into hours, minutes and seconds
// depends on ecfat_pkg
`default_nettype none

module ecfat_tod (
   input  logic                clock,
   input  logic [16:0]         tod_secs,
   output ecfat_pkg::tod_type  tod_out
);

   logic [16:0] t1_rem_ff;
   logic [4:0]  t1_hour_ff;
   logic [4:0]  t1_hour_in;
   logic [22:0] hour_prod;

   logic [11:0] t2_rem_ff;
   logic [4:0]  t2_hour_ff;
   logic [11:0] t2_rem_in;
   logic [4:0]  t2_hour_in;
   logic [16:0] hour_mul;
   logic [16:0] hour_rem;
   logic        hour_fix;

   logic [11:0] t3_rem_ff;
   logic [4:0]  t3_hour_ff;
   logic [5:0]  t3_min_ff;
   logic [5:0]  t3_min_in;
   logic [18:0] min_prod;

   ecfat_pkg::tod_type t4_ff;
   ecfat_pkg::tod_type t4_in;
   logic [11:0] min_mul;
   logic [11:0] min_rem;
   logic        min_fix;

   assign hour_prod  = 23'(tod_secs) * 23'(ecfat_pkg::RecipHour);
   assign t1_hour_in = hour_prod[21:17];

   assign hour_mul   = 17'(t1_hour_ff) * 17'(ecfat_pkg::HourSecs);
   assign hour_rem   = t1_rem_ff - hour_mul;
   assign hour_fix   = (hour_rem >= 17'(ecfat_pkg::HourSecs));
   assign t2_rem_in  = hour_fix ? 12'(hour_rem - 17'(ecfat_pkg::HourSecs)) : hour_rem[11:0];
   assign t2_hour_in = t1_hour_ff + 5'(hour_fix);

   assign min_prod   = 19'(t2_rem_ff) * 19'(ecfat_pkg::RecipMin);
   assign t3_min_in  = min_prod[17:12];

   assign min_mul    = 12'(t3_min_ff) * 12'(ecfat_pkg::MinSecs);
   assign min_rem    = t3_rem_ff - min_mul;
   assign min_fix    = (min_rem >= 12'(ecfat_pkg::MinSecs));

   always_comb begin
      t4_in.hours = t3_hour_ff;
      t4_in.mins  = t3_min_ff + 6'(min_fix);
      t4_in.secs  = min_fix ? 6'(min_rem - 12'(ecfat_pkg::MinSecs)) : min_rem[5:0];
   end

   always_ff @(posedge clock) begin
      t1_rem_ff  <= tod_secs;
      t1_hour_ff <= t1_hour_in;
      t2_rem_ff  <= t2_rem_in;
      t2_hour_ff <= t2_hour_in;
      t3_rem_ff  <= t2_rem_ff;
      t3_hour_ff <= t2_hour_ff;
      t3_min_ff  <= t3_min_in;
      t4_ff      <= t4_in;
   end

   assign tod_out = t4_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ecfat_civil.sv =====
// ecfat_civil: eight register stages turning a march-based day count into year, month and day
// depends on ecfat_pkg
`default_nettype none

module ecfat_civil (
   input  logic                  clock,
   input  logic                  reset,
   input  ecfat_pkg::split_type  split_in,
   output ecfat_pkg::civil_type  civil_out
);

   // stage 1: era and day of era
   logic        c1_valid_ff;
   logic        c1_era5_ff;
   logic [17:0] c1_eday_ff;
   logic        c1_era5_in;
   logic [17:0] c1_eday_in;

   // stage 2: estimate of eday / 1460, century and last day flags
   logic        c2_valid_ff;
   logic        c2_era5_ff;
   logic [17:0] c2_eday_ff;
   logic [7:0]  c2_quad_ff;
   logic [2:0]  c2_cent_ff;
   logic        c2_last_ff;
   logic [25:0] quad_prod;
   logic [2:0]  c2_cent_in;

   // stage 3: corrected quotient and year numerator
   logic        c3_valid_ff;
   logic        c3_era5_ff;
   logic [17:0] c3_eday_ff;
   logic [17:0] c3_num_ff;
   logic [17:0] quad_mul;
   logic [17:0] quad_rem;
   logic [7:0]  quad_adj;
   logic [17:0] c3_num_in;

   // stage 4: estimate of year of era
   logic        c4_valid_ff;
   logic        c4_era5_ff;
   logic [17:0] c4_eday_ff;
   logic [17:0] c4_num_ff;
   logic [8:0]  c4_year_ff;
   logic [27:0] year_prod;

   // stage 5: corrected year of era
   logic        c5_valid_ff;
   logic        c5_era5_ff;
   logic [17:0] c5_eday_ff;
   logic [8:0]  c5_year_ff;
   logic [17:0] year_mul;
   logic [17:0] year_rem;
   logic [8:0]  c5_year_in;

   // stage 6: day of year
   logic        c6_valid_ff;
   logic        c6_era5_ff;
   logic [8:0]  c6_year_ff;
   logic [8:0]  c6_yday_ff;
   logic [1:0]  cent_years;
   logic [17:0] year_start;
   logic [17:0] c6_yday_in;

   // stage 7: march-based month
   logic        c7_valid_ff;
   logic        c7_era5_ff;
   logic [8:0]  c7_year_ff;
   logic [8:0]  c7_yday_ff;
   logic [3:0]  c7_mp_ff;
   logic [3:0]  c7_mp_in;

   // stage 8: calendar fields
   ecfat_pkg::civil_type c8_ff;
   ecfat_pkg::civil_type c8_in;
   logic [3:0]  month_val;

   assign c1_era5_in = (split_in.days >= ecfat_pkg::EraFiveStart);
   assign c1_eday_in = c1_era5_in ? 18'(split_in.days - ecfat_pkg::EraFiveStart)
                                  : 18'(split_in.days - ecfat_pkg::EraFourStart);

   assign quad_prod  = 26'(c1_eday_ff) * 26'(ecfat_pkg::RecipQuad);
   assign c2_cent_in = 3'(c1_eday_ff >= ecfat_pkg::CenturyDays)
                     + 3'(c1_eday_ff >= 18'(2 * ecfat_pkg::CenturyDays))
                     + 3'(c1_eday_ff >= 18'(3 * ecfat_pkg::CenturyDays))
                     + 3'(c1_eday_ff >= 18'(4 * ecfat_pkg::CenturyDays));

   assign quad_mul  = 18'(c2_quad_ff) * 18'(ecfat_pkg::QuadLess);
   assign quad_rem  = c2_eday_ff - quad_mul;
   assign quad_adj  = c2_quad_ff + 8'(quad_rem >= 18'(ecfat_pkg::QuadLess));
   assign c3_num_in = c2_eday_ff - 18'(quad_adj) + 18'(c2_cent_ff) - 18'(c2_last_ff);

   assign year_prod = 28'(c3_num_ff) * 28'(ecfat_pkg::RecipYear);

   assign year_mul   = 18'(c4_year_ff) * 18'(ecfat_pkg::YearDays);
   assign year_rem   = c4_num_ff - year_mul;
   assign c5_year_in = c4_year_ff + 9'(year_rem >= 18'(ecfat_pkg::YearDays));

   assign cent_years = 2'(c5_year_ff >= ecfat_pkg::CenturyYears)
                     + 2'(c5_year_ff >= 9'(2 * ecfat_pkg::CenturyYears))
                     + 2'(c5_year_ff >= 9'(3 * ecfat_pkg::CenturyYears));
   assign year_start = 18'(c5_year_ff) * 18'(ecfat_pkg::YearDays)
                     + 18'(c5_year_ff[8:2]) - 18'(cent_years);
   assign c6_yday_in = c5_eday_ff - year_start;

   always_comb begin
      c7_mp_in = 4'd0;
      for (int i = 1; i < int'(ecfat_pkg::MonthsInYear); i++) begin
         c7_mp_in = c7_mp_in + 4'(c6_yday_ff >= ecfat_pkg::month_start(4'(i)));
      end
   end

   assign month_val = (c7_mp_ff < 4'd10) ? (c7_mp_ff + 4'd3) : (c7_mp_ff - 4'd9);

   always_comb begin
      c8_in.valid = c7_valid_ff;
      c8_in.month = month_val;
      c8_in.day   = 5'(c7_yday_ff - ecfat_pkg::month_start(c7_mp_ff) + 9'd1);
      c8_in.year  = 12'(c7_year_ff)
                  + (c7_era5_ff ? ecfat_pkg::EraFiveYear : ecfat_pkg::EraFourYear)
                  + 12'(month_val <= 4'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
         c3_valid_ff <= 1'b0;
         c4_valid_ff <= 1'b0;
         c5_valid_ff <= 1'b0;
         c6_valid_ff <= 1'b0;
         c7_valid_ff <= 1'b0;
         c8_ff.valid <= 1'b0;
      end else begin
         c1_valid_ff <= split_in.valid;
         c2_valid_ff <= c1_valid_ff;
         c3_valid_ff <= c2_valid_ff;
         c4_valid_ff <= c3_valid_ff;
         c5_valid_ff <= c4_valid_ff;
         c6_valid_ff <= c5_valid_ff;
         c7_valid_ff <= c6_valid_ff;
         c8_ff.valid <= c8_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      c1_era5_ff  <= c1_era5_in;
      c1_eday_ff  <= c1_eday_in;
      c2_era5_ff  <= c1_era5_ff;
      c2_eday_ff  <= c1_eday_ff;
      c2_quad_ff  <= quad_prod[25:18];
      c2_cent_ff  <= c2_cent_in;
      c2_last_ff  <= (c1_eday_ff == ecfat_pkg::EraLastDay);
      c3_era5_ff  <= c2_era5_ff;
      c3_eday_ff  <= c2_eday_ff;
      c3_num_ff   <= c3_num_in;
      c4_era5_ff  <= c3_era5_ff;
      c4_eday_ff  <= c3_eday_ff;
      c4_num_ff   <= c3_num_ff;
      c4_year_ff  <= year_prod[26:18];
      c5_era5_ff  <= c4_era5_ff;
      c5_eday_ff  <= c4_eday_ff;
      c5_year_ff  <= c5_year_in;
      c6_era5_ff  <= c5_era5_ff;
      c6_year_ff  <= c5_year_ff;
      c6_yday_ff  <= c6_yday_in[8:0];
      c7_era5_ff  <= c6_era5_ff;
      c7_year_ff  <= c6_year_ff;
      c7_yday_ff  <= c6_yday_ff;
      c7_mp_ff    <= c7_mp_in;
      c8_ff.year  <= c8_in.year;
      c8_ff.month <= c8_in.month;
      c8_ff.day   <= c8_in.day;
   end

   assign civil_out = c8_ff;

endmodule

`default_nettype wire

// ===== rtl/core/epoch_seconds_to_fat_timestamp_top.sv =====
// throughput: one item per cycle while busy is low, fully pipelined; 3 split, 8 calendar and 1 output stage
// busy follows reset and is low otherwise; the result side never stalls
// reset clears every pipeline valid bit (items in flight are dropped) and
// loads the default date registers with 2020-01-01
// depends on ecfat_pkg, ecfat_split, ecfat_tod, ecfat_civil
`default_nettype none

module epoch_seconds_to_fat_timestamp_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_epoch_seconds,
   output logic               rsp_valid,
   output logic [31:0]        rsp_fat_stamp,
   output logic               rsp_used_default,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [11:0]        csr_wdata
);

   ecfat_pkg::split_type split_q;
   ecfat_pkg::tod_type   tod_q;
   ecfat_pkg::civil_type civil_q;

   logic [11:0] cfg_year_ff;
   logic [3:0]  cfg_month_ff;
   logic [4:0]  cfg_day_ff;

   logic               zero_dly_ff [ecfat_pkg::CivilStages];
   ecfat_pkg::tod_type tod_dly_ff  [ecfat_pkg::TodDelay];

   logic        rsp_valid_ff;
   logic [31:0] rsp_stamp_ff;
   logic        rsp_default_ff;
   logic [31:0] rsp_stamp_in;

   logic        use_default;
   logic [11:0] year_off;
   logic [3:0]  month_sel;
   logic [4:0]  day_sel;
   ecfat_pkg::tod_type tod_sel;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   ecfat_split u_split (
      .clock         (clock),
      .reset         (reset),
      .start_accept  (start && !busy),
      .epoch_seconds (req_epoch_seconds),
      .split_out     (split_q)
   );

   ecfat_tod u_tod (
      .clock    (clock),
      .tod_secs (split_q.tod_secs),
      .tod_out  (tod_q)
   );

   ecfat_civil u_civil (
      .clock     (clock),
      .reset     (reset),
      .split_in  (split_q),
      .civil_out (civil_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_year_ff  <= ecfat_pkg::ResetYear;
         cfg_month_ff <= ecfat_pkg::ResetMonth;
         cfg_day_ff   <= ecfat_pkg::ResetDay;
      end else if (csr_valid && csr_ready) begin
         unique case (ecfat_pkg::csr_index_type'(csr_index))
            ecfat_pkg::CSR_YEAR:  cfg_year_ff  <= csr_wdata;
            ecfat_pkg::CSR_MONTH: cfg_month_ff <= csr_wdata[3:0];
            ecfat_pkg::CSR_DAY:   cfg_day_ff   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // align zero flag and time of day with the calendar stages
   always_ff @(posedge clock) begin
      zero_dly_ff[0] <= split_q.zero;
      for (int i = 1; i < int'(ecfat_pkg::CivilStages); i++) begin
         zero_dly_ff[i] <= zero_dly_ff[i-1];
      end
      tod_dly_ff[0] <= tod_q;
      for (int i = 1; i < int'(ecfat_pkg::TodDelay); i++) begin
         tod_dly_ff[i] <= tod_dly_ff[i-1];
      end
   end

   assign use_default = zero_dly_ff[ecfat_pkg::CivilStages-1];

   always_comb begin
      if (use_default) begin
         year_off  = cfg_year_ff - ecfat_pkg::BaseYear;
         month_sel = cfg_month_ff;
         day_sel   = cfg_day_ff;
         tod_sel   = '0;
      end else begin
         year_off  = civil_q.year - ecfat_pkg::BaseYear;
         month_sel = civil_q.month;
         day_sel   = civil_q.day;
         tod_sel   = tod_dly_ff[ecfat_pkg::TodDelay-1];
      end
      // seconds go in undivided
      rsp_stamp_in = {year_off[6:0], month_sel, day_sel, tod_sel.hours, tod_sel.mins, 5'd0}
                   | {26'd0, tod_sel.secs};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= civil_q.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_stamp_ff   <= rsp_stamp_in;
      rsp_default_ff <= use_default;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fat_stamp    = rsp_stamp_ff;
   assign rsp_used_default = rsp_default_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ecfat_checker.sv =====
// ecfat_checker: port-level assertions for the epoch to fat timestamp top level
// bound to epoch_seconds_to_fat_timestamp_top; no package dependency
`default_nettype none

module ecfat_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [31:0] req_epoch_seconds,
   input logic               rsp_valid,
   input logic [31:0]        rsp_fat_stamp,
   input logic               rsp_used_default
);

   a_item_completes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##12 rsp_valid)
      else $error("accepted item gave no result after 12 cycles");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 12))
      else $error("result without an accepted item");

   a_default_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_used_default == $past(req_epoch_seconds == 32'sd0, 12)))
      else $error("default flag does not match a zero input");

   a_calendar_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_used_default) |->
         (rsp_fat_stamp[24:21] != 4'd0) && (rsp_fat_stamp[24:21] <= 4'd12) &&
         (rsp_fat_stamp[20:16] != 5'd0) && (rsp_fat_stamp[15:11] <= 5'd23))
      else $error("converted date or hour out of range");

   a_default_midnight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_used_default) |-> (rsp_fat_stamp[15:0] == 16'd0))
      else $error("default date carries a nonzero time");

endmodule

bind epoch_seconds_to_fat_timestamp_top ecfat_checker u_ecfat_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_epoch_seconds (req_epoch_seconds),
   .rsp_valid         (rsp_valid),
   .rsp_fat_stamp     (rsp_fat_stamp),
   .rsp_used_default  (rsp_used_default)
);

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for epoch_seconds_to_fat_timestamp_top
// directed table then random epoch seconds under several default dates, each result checked
// depends on ecfat_pkg and the rtl under rtl/core

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint SecPerMin   = 60;
   localparam longint SecPerHour  = 3600;
   localparam longint SecPerDay   = 86400;
   localparam longint MarchShift  = 719468;
   localparam longint EraDays     = 146097;
   localparam longint CentDays    = 36524;
   localparam longint QuadDays    = 1461;
   localparam longint DaysPerYear = 365;
   localparam longint MonthSpan   = 153;
   localparam longint FatBaseYear = 1980;

   localparam logic [1:0] CsrSpare = 2'd3;

   localparam int StallLimit  = 2000;
   localparam int DrainCycles = 24;
   localparam int PhaseItems  = 215;
   localparam int NumPhases   = 7;

   typedef struct packed {
      logic [31:0] fat_stamp;
      logic        used_default;
   } fat_result_type;

   typedef struct packed {
      logic signed [31:0] secs;
      logic               typed;
      fat_result_type     want;
   } stamp_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_epoch_seconds = '0;
   logic               rsp_valid;
   logic [31:0]        rsp_fat_stamp;
   logic               rsp_used_default;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [11:0]        csr_wdata = '0;

   logic [11:0] dflt_year  = ecfat_pkg::ResetYear;
   logic [3:0]  dflt_month = ecfat_pkg::ResetMonth;
   logic [4:0]  dflt_day   = ecfat_pkg::ResetDay;

   fat_result_type expected_stamps[$];
   int          errors = 0;
   int          items_sent = 0;
   int          zero_items = 0;
   int          settings_used = 1;
   int          stall_cycles = 0;
   bit          gaps_on = 1'b1;

   stamp_row_type directed_rows [22] = '{
      '{32'sd0,          1'b1, '{32'h5021_0000, 1'b1}},
      '{32'sd2147483647, 1'b1, '{32'h7433_19C7, 1'b0}},
      '{32'h8000_0000,   1'b1, '{32'h638D_A5B4, 1'b0}},
      '{-32'sd1,         1'b1, '{32'hEB9F_BF7B, 1'b0}},
      '{32'sd1,          1'b0, '{32'h0, 1'b0}},
      '{32'sd32,         1'b0, '{32'h0, 1'b0}},
      '{32'sd59,         1'b0, '{32'h0, 1'b0}},
      '{32'sd60,         1'b0, '{32'h0, 1'b0}},
      '{32'sd3599,       1'b0, '{32'h0, 1'b0}},
      '{32'sd86399,      1'b0, '{32'h0, 1'b0}},
      '{32'sd86400,      1'b0, '{32'h0, 1'b0}},
      '{-32'sd86400,     1'b0, '{32'h0, 1'b0}},
      '{-32'sd86401,     1'b0, '{32'h0, 1'b0}},
      '{32'sd315532799,  1'b0, '{32'h0, 1'b0}},
      '{32'sd315532800,  1'b0, '{32'h0, 1'b0}},
      '{32'sd946684799,  1'b0, '{32'h0, 1'b0}},
      '{32'sd951782400,  1'b0, '{32'h0, 1'b0}},
      '{32'sd951868800,  1'b0, '{32'h0, 1'b0}},
      '{32'sd1709164800, 1'b0, '{32'h0, 1'b0}},
      '{-32'sd631152000, 1'b0, '{32'h0, 1'b0}},
      '{32'h5555_5555,   1'b0, '{32'h0, 1'b0}},
      '{32'hAAAA_AAAA,   1'b0, '{32'h0, 1'b0}}
   };

   epoch_seconds_to_fat_timestamp_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_epoch_seconds(req_epoch_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_fat_stamp    (rsp_fat_stamp),
      .rsp_used_default (rsp_used_default),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] pack_fat_date(input longint year, input logic [3:0] month,
                                                 input logic [4:0] day);
      longint yoff;
      yoff = (year - FatBaseYear) & 127;
      return {yoff[6:0], month, day, 16'h0000};
   endfunction

   function automatic fat_result_type predict_fat_stamp(input logic signed [31:0] secs);
      longint         t, days, rem, era, eday, eyear, yday, mp, year;
      longint         hours, mins, sec_part, month, day;
      fat_result_type r;
      t = secs;
      if (t == 0) begin
         r.fat_stamp    = pack_fat_date(longint'(dflt_year), dflt_month, dflt_day);
         r.used_default = 1'b1;
         return r;
      end
      days = t / SecPerDay;
      rem  = t % SecPerDay;
      if (rem < 0) begin
         rem  += SecPerDay;
         days -= 1;
      end
      days += MarchShift;
      hours    = rem / SecPerHour;
      rem      = rem % SecPerHour;
      mins     = rem / SecPerMin;
      sec_part = rem % SecPerMin;
      era   = (days >= 0 ? days : days - (EraDays - 1)) / EraDays;
      eday  = days - era * EraDays;
      eyear = (eday - eday / (QuadDays - 1) + eday / CentDays - eday / (EraDays - 1))
              / DaysPerYear;
      yday  = eday - (DaysPerYear * eyear + eyear / 4 - eyear / 100);
      mp    = (5 * yday + 2) / MonthSpan;
      day   = yday - (MonthSpan * mp + 2) / 5 + 1;
      month = (mp < 10) ? mp + 3 : mp - 9;
      year  = eyear + era * 400 + ((month <= 2) ? 1 : 0);
      // seconds go in undivided, so their bit 5 overlaps the lowest minute bit
      r.fat_stamp = pack_fat_date(year, month[3:0], day[4:0])
                    | 32'({hours[4:0], 11'h000})
                    | 32'({mins[5:0], 5'h00}) | 32'(sec_part[5:0]);
      r.used_default = 1'b0;
      return r;
   endfunction

   function automatic logic signed [31:0] random_seconds();
      longint v;
      case ($urandom_range(9))
         0, 1, 2: v = longint'($urandom);
         3:       v = 0;
         4:       v = (longint'($urandom_range(49710)) - 24855) * SecPerDay
                      + longint'($urandom_range(2)) - 1;
         5:       v = longint'($urandom_range(200)) - 100;
         6:       v = $urandom_range(1) ? 64'sd2147483647 - longint'($urandom_range(86400))
                                        : -64'sd2147483648 + longint'($urandom_range(86400));
         7:       v = (longint'($urandom_range(49710)) - 24855) * SecPerDay
                      + longint'($urandom_range(86399));
         default: v = longint'($urandom_range(32'h7FFF_FFFF));
      endcase
      return v[31:0];
   endfunction

   task automatic send_item(input logic signed [31:0] secs, input logic typed,
                            input fat_result_type want);
      if (gaps_on && $urandom_range(99) < 8) begin
         start <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      start             <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (busy);
      expected_stamps.push_back(typed ? want : predict_fat_stamp(secs));
      if (secs == 0) zero_items++;
      items_sent++;
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      do @(posedge clock); while (expected_stamps.size() != 0);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [11:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ecfat_pkg::CSR_YEAR:  dflt_year  = data;
         ecfat_pkg::CSR_MONTH: dflt_month = data[3:0];
         ecfat_pkg::CSR_DAY:   dflt_day   = data[4:0];
         default: ;
      endcase
   endtask

   task automatic load_defaults(input logic [11:0] year, input logic [3:0] month,
                                input logic [4:0] day);
      write_csr(ecfat_pkg::CSR_YEAR, year);
      write_csr(CsrSpare, 12'($urandom));
      write_csr(ecfat_pkg::CSR_MONTH, {8'($urandom), month});
      write_csr(ecfat_pkg::CSR_DAY, {7'($urandom), day});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   always @(posedge clock) begin
      fat_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_stamps.size() == 0) begin
            $error("result with no item outstanding: fat_stamp %h", rsp_fat_stamp);
            errors++;
         end else begin
            want = expected_stamps.pop_front();
            if (rsp_fat_stamp !== want.fat_stamp) begin
               $error("fat_stamp expected %h actual %h", want.fat_stamp, rsp_fat_stamp);
               errors++;
            end
            if (rsp_used_default !== want.used_default) begin
               $error("used_default expected %b actual %b", want.used_default,
                      rsp_used_default);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= StallLimit) begin
         $error("no progress for %0d cycles", StallLimit);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_item(directed_rows[i].secs, directed_rows[i].typed, directed_rows[i].want);
      for (int phase = 0; phase < NumPhases; phase++) begin
         if (phase > 0) begin
            drain_pipeline();
            case (phase)
               1: load_defaults(12'd1980, 4'd1, 5'd1);
               2: load_defaults(12'd2107, 4'd12, 5'd31);
               3: load_defaults(12'd0, 4'd0, 5'd0);
               4: load_defaults(12'hFFF, 4'hF, 5'h1F);
               default: load_defaults(12'($urandom), 4'($urandom), 5'($urandom));
            endcase
         end
         // one whole phase runs back to back
         gaps_on = (phase != 3);
         repeat (PhaseItems) send_item(random_seconds(), 1'b0, '0);
      end
      drain_pipeline();
      repeat (DrainCycles) @(posedge clock);
      if (expected_stamps.size() != 0) begin
         $error("%0d items never produced a result", expected_stamps.size());
         errors += expected_stamps.size();
      end
      $display("converted %0d timestamps, %0d of them zero, under %0d default-date settings",
               items_sent, zero_items, settings_used);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
